// File: design/indexed_bmp_stream_parser_unit_defines.svh
// Assertion macros for the indexed BMP stream parser RTL.
// The including module must have clk_i and rst_ni in scope.
`ifndef INDEXED_BMP_STREAM_PARSER_UNIT_DEFINES_SVH
`define INDEXED_BMP_STREAM_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define IBSP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define IBSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ibsp_pkg.sv
// Package for the indexed BMP stream parser: size limits, result codes
// and the word types shared by the parser core and the top level.
`timescale 1ns / 1ps

package ibsp_pkg;

  // Largest accepted image width or height in pixels.
  localparam int unsigned MAX_DIM = 4096;
  // Internal width of dimension and pixel counters.
  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  // Width of the dimension fields on the result channel.
  localparam int unsigned OUT_DIM_W = 13;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PALETTE = 2'd1,
    KIND_PIXEL   = 2'd2,
    KIND_ERROR   = 2'd3
  } result_kind_e;

  typedef enum logic [3:0] {
    ERR_MAGIC       = 4'd0,
    ERR_HDR_SIZE    = 4'd1,
    ERR_NEG_OFFSET  = 4'd2,
    ERR_NOT_MULT16  = 4'd3,
    ERR_PLANES      = 4'd4,
    ERR_BPP         = 4'd5,
    ERR_COMPRESSED  = 4'd6,
    ERR_PALETTE     = 4'd7,
    ERR_TOO_LARGE   = 4'd8
  } error_code_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_word_t;

  typedef struct packed {
    result_kind_e           kind;
    error_code_e            error_code;
    logic [OUT_DIM_W-1:0]   image_width;
    logic [OUT_DIM_W-1:0]   image_height;
    logic [7:0]             entry_index;
    logic [7:0]             red;
    logic [7:0]             green;
    logic [7:0]             blue;
    logic [7:0]             pixel_value;
    logic                   last;
  } result_t;

endpackage

// File: design/ibsp_in_if.sv
// Byte input channel of the indexed BMP stream parser.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps

interface ibsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;

  modport source (output valid, output data_byte, output start_of_file, input ready);
  modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

// File: design/ibsp_out_if.sv
// Result output channel of the indexed BMP stream parser.
// Valid/ready handshake; the dimension field widths come from ibsp_pkg.
`timescale 1ns / 1ps

interface ibsp_out_if import ibsp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           result_kind;
  logic [3:0]           error_code;
  logic [OUT_DIM_W-1:0] image_width_out;
  logic [OUT_DIM_W-1:0] image_height_out;
  logic [7:0]           entry_index;
  logic [7:0]           red;
  logic [7:0]           green;
  logic [7:0]           blue;
  logic [7:0]           pixel_value;
  logic                 last;

  modport source (
    output valid, output result_kind, output error_code, output image_width_out,
    output image_height_out, output entry_index, output red, output green,
    output blue, output pixel_value, output last, input ready
  );
  modport sink (
    input valid, input result_kind, input error_code, input image_width_out,
    input image_height_out, input entry_index, input red, input green,
    input blue, input pixel_value, input last, output ready
  );
endinterface

// File: design/indexed_bmp_stream_parser_unit.sv
// Top level of the indexed BMP stream parser: input word register, parser core
// and result register. Depends on ibsp_pkg, ibsp_in_if, ibsp_out_if, ibsp_parser.
`timescale 1ns / 1ps
`include "indexed_bmp_stream_parser_unit_defines.svh"

// Usage notes.
// The byte_i channel carries one word per file byte: data_byte and a
// start_of_file flag that marks the first byte of a new file and restarts the
// parser. The result_o channel carries at most one word per accepted byte: the
// header result on byte 53, one palette entry on every fourth palette byte, one
// pixel index per pixel byte, or a single error word with last set. Gap bytes,
// non-final header bytes that pass their checks and bytes that arrive after the
// end of a file (or after an error) produce no result.
// A byte accepted into the input register is parsed from that register and its
// result is loaded into the result register, where result_o.valid rises.
// Throughput is one byte per cycle as long as the receiver keeps ready high.
// When the receiver stalls, the result register holds its word and the input
// register fills; byte_i.ready then drops until the result is taken, so no word
// is ever dropped or repeated.
// Reset clears both valid flags and puts the parser in its header phase, so a
// stream with no start_of_file mark is parsed from its first byte.

module indexed_bmp_stream_parser_unit import ibsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ibsp_in_if.sink    byte_i,
  ibsp_out_if.source result_o
);

  logic     stg_valid_q;
  in_word_t stg_word_q;
  logic     out_valid_q;
  result_t  out_q;

  logic     out_free;
  logic     advance;
  logic     in_ready;
  result_t  par_result;
  logic     par_valid;

  // The result register can take a new word when empty or being drained.
  assign out_free = !out_valid_q || result_o.ready;
  // The parser steps on the held byte whenever its result has a place to go.
  assign advance  = stg_valid_q && out_free;
  assign in_ready = !stg_valid_q || out_free;

  assign byte_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        stg_valid_q <= byte_i.valid;
      end
      if (out_free) begin
        out_valid_q <= advance && par_valid;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_ready && byte_i.valid) begin
      stg_word_q.data_byte     <= byte_i.data_byte;
      stg_word_q.start_of_file <= byte_i.start_of_file;
    end
    if (advance && par_valid) begin
      out_q <= par_result;
    end
  end

  ibsp_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .word_i         (stg_word_q),
    .result_o       (par_result),
    .result_valid_o (par_valid)
  );

  assign result_o.valid            = out_valid_q;
  assign result_o.result_kind      = out_q.kind;
  assign result_o.error_code       = out_q.error_code;
  assign result_o.image_width_out  = out_q.image_width;
  assign result_o.image_height_out = out_q.image_height;
  assign result_o.entry_index      = out_q.entry_index;
  assign result_o.red              = out_q.red;
  assign result_o.green            = out_q.green;
  assign result_o.blue             = out_q.blue;
  assign result_o.pixel_value      = out_q.pixel_value;
  assign result_o.last             = out_q.last;

  `IBSP_ASSERT_IMPL(a_error_is_last, out_valid_q && (out_q.kind == KIND_ERROR), out_q.last,
    "error word without last")
  `IBSP_ASSERT_IMPL(a_header_not_last, out_valid_q && (out_q.kind == KIND_HEADER), !out_q.last,
    "header word marked last")
  `IBSP_ASSERT_IMPL(a_stall_only_when_full, !in_ready,
    stg_valid_q && out_valid_q && !result_o.ready, "input stalled with room in the pipeline")
  `IBSP_ASSERT_NEXT(a_result_loaded, advance && par_valid, out_valid_q,
    "parsed result not loaded into the result register")

endmodule

// File: design/ibsp_parser.sv
// Parser core: holds the header, palette and pixel state and turns one byte
// into at most one result per step. Depends on ibsp_pkg.
`timescale 1ns / 1ps

module ibsp_parser import ibsp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  in_word_t word_i,
  output result_t  result_o,
  output logic     result_valid_o
);

  localparam int unsigned POS_W = 6;

  localparam logic [POS_W-1:0] POS_MAGIC_B   = 6'd0;
  localparam logic [POS_W-1:0] POS_MAGIC_M   = 6'd1;
  localparam logic [POS_W-1:0] POS_OFFSET    = 6'd13;
  localparam logic [POS_W-1:0] POS_HDR_SIZE  = 6'd17;
  localparam logic [POS_W-1:0] POS_WIDTH     = 6'd21;
  localparam logic [POS_W-1:0] POS_HEIGHT    = 6'd25;
  localparam logic [POS_W-1:0] POS_PLANES    = 6'd27;
  localparam logic [POS_W-1:0] POS_BPP       = 6'd29;
  localparam logic [POS_W-1:0] POS_COMPRESS  = 6'd31;
  localparam logic [POS_W-1:0] POS_PAL_CHECK = 6'd51;
  localparam logic [POS_W-1:0] POS_HDR_END   = 6'd53;

  // Pixel data offset that leaves exactly 256 palette entries plus a gap of 0 to 3.
  localparam logic [31:0] OFFSET_MIN = 32'd1078;
  localparam logic [31:0] OFFSET_MAX = 32'd1081;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_PALETTE,
    PH_GAP,
    PH_PIXELS,
    PH_IDLE
  } phase_e;

  phase_e             phase_q, phase_d, phase_cur;
  logic [POS_W-1:0]   pos_q, pos_d, pos_cur;
  logic [23:0]        shift_q, shift_d, shift_cur;
  logic               off_neg_q, off_neg_d;
  logic               off_ok_q, off_ok_d;
  logic [1:0]         gap_q, gap_d;
  logic [DIM_W-1:0]   width_q, width_d;
  logic               width_big_q, width_big_d;
  logic [DIM_W-1:0]   height_q, height_d;
  logic [23:0]        partial_q, partial_d;
  logic [7:0]         pal_q, pal_d;
  logic [DIM_W-1:0]   col_q, col_d;
  logic [DIM_W-1:0]   row_q, row_d;

  logic [31:0]        field;
  logic [15:0]        hi16;
  logic [1:0]         pal_k;
  logic               fin;
  logic               sof;
  logic [7:0]         b;
  result_t            res;
  logic               res_valid;

  function automatic result_t err_result(error_code_e code);
    result_t r;
    r            = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    r.last       = 1'b1;
    return r;
  endfunction

  always_comb begin
    b   = word_i.data_byte;
    sof = word_i.start_of_file;

    // A start-of-file byte restarts the parser and is taken as header byte zero.
    phase_cur = sof ? PH_HEADER : phase_q;
    pos_cur   = sof ? '0 : pos_q;
    shift_cur = sof ? '0 : shift_q;

    phase_d     = phase_cur;
    pos_d       = pos_cur;
    shift_d     = shift_cur;
    off_neg_d   = sof ? 1'b0 : off_neg_q;
    off_ok_d    = sof ? 1'b0 : off_ok_q;
    gap_d       = sof ? '0 : gap_q;
    width_d     = sof ? '0 : width_q;
    width_big_d = sof ? 1'b0 : width_big_q;
    height_d    = sof ? '0 : height_q;
    partial_d   = sof ? '0 : partial_q;
    pal_d       = sof ? '0 : pal_q;
    col_d       = sof ? '0 : col_q;
    row_d       = sof ? '0 : row_q;

    field = {b, shift_cur};
    hi16  = field[31:16];
    pal_k = pos_cur[1:0];
    fin   = ((row_q + 1'b1) == height_q) && ((col_q + 1'b1) == width_q);

    res       = '0;
    res_valid = 1'b0;

    unique case (phase_cur)
      PH_HEADER: begin
        pos_d   = pos_cur + 1'b1;
        shift_d = field[31:8];
        case (pos_cur)
          POS_MAGIC_B: begin
            if (b != 8'h42) begin
              res = err_result(ERR_MAGIC);
              res_valid = 1'b1;
            end
          end
          POS_MAGIC_M: begin
            if (b != 8'h4D) begin
              res = err_result(ERR_MAGIC);
              res_valid = 1'b1;
            end
          end
          POS_OFFSET: begin
            off_neg_d = field[31];
            off_ok_d  = (field >= OFFSET_MIN) && (field <= OFFSET_MAX);
            gap_d     = field[1:0] - OFFSET_MIN[1:0];
          end
          POS_HDR_SIZE: begin
            if (field != 32'd40) begin
              res = err_result(ERR_HDR_SIZE);
              res_valid = 1'b1;
            end else if (off_neg_q) begin
              res = err_result(ERR_NEG_OFFSET);
              res_valid = 1'b1;
            end
          end
          POS_WIDTH: begin
            width_d     = field[DIM_W-1:0];
            width_big_d = field > 32'(MAX_DIM);
          end
          POS_HEIGHT: begin
            height_d = field[DIM_W-1:0];
            if ((width_q[3:0] != 4'd0) || (field[3:0] != 4'd0)) begin
              res = err_result(ERR_NOT_MULT16);
              res_valid = 1'b1;
            end else if (width_big_q || (field > 32'(MAX_DIM))) begin
              res = err_result(ERR_TOO_LARGE);
              res_valid = 1'b1;
            end
          end
          POS_PLANES: begin
            if (hi16 != 16'd1) begin
              res = err_result(ERR_PLANES);
              res_valid = 1'b1;
            end
          end
          POS_BPP: begin
            if (hi16 != 16'd8) begin
              res = err_result(ERR_BPP);
              res_valid = 1'b1;
            end
          end
          POS_COMPRESS: begin
            if (hi16 != 16'd0) begin
              res = err_result(ERR_COMPRESSED);
              res_valid = 1'b1;
            end
          end
          POS_PAL_CHECK: begin
            if (!off_ok_q) begin
              res = err_result(ERR_PALETTE);
              res_valid = 1'b1;
            end
          end
          POS_HDR_END: begin
            phase_d          = PH_PALETTE;
            pos_d            = '0;
            pal_d            = '0;
            partial_d        = '0;
            res.kind         = KIND_HEADER;
            res.image_width  = OUT_DIM_W'(width_q);
            res.image_height = OUT_DIM_W'(height_q);
            res_valid        = 1'b1;
          end
          default: begin
          end
        endcase
        if (res_valid && (res.kind == KIND_ERROR)) begin
          phase_d = PH_IDLE;
        end
      end

      PH_PALETTE: begin
        pos_d = {{(POS_W-2){1'b0}}, pal_k + 2'd1};
        case (pal_k)
          2'd0: partial_d = {16'd0, b};
          2'd1: partial_d = {8'd0, b, partial_q[7:0]};
          2'd2: partial_d = {b, partial_q[15:0]};
          default: begin
            // Fourth byte of an entry is alpha: emit the assembled color.
            res.kind        = KIND_PALETTE;
            res.entry_index = pal_q;
            res.red         = partial_q[23:16];
            res.green       = partial_q[15:8];
            res.blue        = partial_q[7:0];
            res_valid       = 1'b1;
            pal_d           = pal_q + 1'b1;
            if (pal_q == 8'hFF) begin
              col_d = '0;
              row_d = '0;
              if ((width_q == '0) || (height_q == '0)) begin
                res.last = 1'b1;
                phase_d  = PH_IDLE;
              end else if (gap_q != 2'd0) begin
                phase_d = PH_GAP;
              end else begin
                phase_d = PH_PIXELS;
              end
            end
          end
        endcase
      end

      PH_GAP: begin
        gap_d = gap_q - 1'b1;
        if (gap_q == 2'd1) begin
          phase_d = PH_PIXELS;
        end
      end

      PH_PIXELS: begin
        res.kind        = KIND_PIXEL;
        res.pixel_value = b;
        res.last        = fin;
        res_valid       = 1'b1;
        if ((col_q + 1'b1) >= width_q) begin
          col_d = '0;
          row_d = row_q + 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
        if (fin) begin
          phase_d = PH_IDLE;
        end
      end

      PH_IDLE: begin
      end

      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      pos_q       <= '0;
      shift_q     <= '0;
      off_neg_q   <= 1'b0;
      off_ok_q    <= 1'b0;
      gap_q       <= '0;
      width_q     <= '0;
      width_big_q <= 1'b0;
      height_q    <= '0;
      partial_q   <= '0;
      pal_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      shift_q     <= shift_d;
      off_neg_q   <= off_neg_d;
      off_ok_q    <= off_ok_d;
      gap_q       <= gap_d;
      width_q     <= width_d;
      width_big_q <= width_big_d;
      height_q    <= height_d;
      partial_q   <= partial_d;
      pal_q       <= pal_d;
      col_q       <= col_d;
      row_q       <= row_d;
    end
  end

  assign result_o       = res;
  assign result_valid_o = res_valid;

endmodule
